@@ rtl/asymmetric_overdrive_shaper_assert.svh @@
// assertion macros for the overdrive shaper pipeline
// expects clk and arst_n in the scope of each use
`ifndef ASYMMETRIC_OVERDRIVE_SHAPER_ASSERT_SVH
`define ASYMMETRIC_OVERDRIVE_SHAPER_ASSERT_SVH

// same-cycle implication
`define AOS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shaper assertion failed");

// next-cycle implication
`define AOS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shaper assertion failed");

`endif

@@ rtl/aos_pkg.sv @@
// shared types, constants and elaboration helpers of the overdrive shaper
// no dependencies
`timescale 1ns / 1ps

package aos_pkg;

	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [16:0] ONE_Q16 = 17'h1_0000;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RAIL_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 2'd1;
	localparam logic [34:0] ERR_MAX = 35'h0_7FFF_FFFF;

	// control and sample carried down the front of the pipeline
	typedef struct packed {
		logic               up;
		logic               lo;
		logic               zero;
		logic               sat;
		logic signed [31:0] x;
	} item_t;

	// rounded q32 product
	function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
		return (a * b + 64'h0000_0000_8000_0000) >> 32;
	endfunction

	// shift-subtract division, used only while building the curve tables
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

endpackage

@@ rtl/aos_curve_rom.sv @@
// tanh and exp curve tables over [0,8), built at elaboration, registered read
// depends on aos_pkg
`timescale 1ns / 1ps

module aos_curve_rom #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] addr,
	output logic [16:0]   tanh_q,
	output logic [16:0]   exp_q
);

	typedef logic [16:0] curve_t [DEPTH];

	// step ratio by series, then tables by repeated rounded products
	function automatic curve_t build_curve(input logic pick_tanh);
		logic [63:0] h;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] r2;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] den;
		logic [63:0] num;
		curve_t c;
		h = (64'd8 << 32) / 64'(DEPTH);
		term = aos_pkg::ONE_Q32;
		r = aos_pkg::ONE_Q32;
		for (int n = 1; n <= 12; n++) begin
			term = aos_pkg::udiv64((term * h) >> 32, 64'(n));
			if ((n & 1) != 0) r = r - term;
			else r = r + term;
		end
		if (r >= aos_pkg::ONE_Q32) r = aos_pkg::ONE_Q32 - 64'd1;
		r2 = aos_pkg::mul_q32(r, r);
		p = aos_pkg::ONE_Q32;
		q = aos_pkg::ONE_Q32;
		for (int k = 0; k < DEPTH; k++) begin
			den = aos_pkg::ONE_Q32 + q;
			num = (aos_pkg::ONE_Q32 - q) << 16;
			if (pick_tanh) c[k] = 17'(aos_pkg::udiv64(num + (den >> 1), den));
			else c[k] = 17'((p + 64'd32768) >> 16);
			p = aos_pkg::mul_q32(p, r);
			q = aos_pkg::mul_q32(q, r2);
		end
		return c;
	endfunction

	localparam curve_t TANH_CURVE = build_curve(1'b1);
	localparam curve_t EXP_CURVE  = build_curve(1'b0);

	// registered read, holds while the stage is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			tanh_q <= TANH_CURVE[addr];
			exp_q  <= EXP_CURVE[addr];
		end
	end

endmodule

@@ rtl/asymmetric_overdrive_shaper.sv @@
// top level of the asymmetric overdrive shaper
// depends on aos_pkg, aos_curve_rom and asymmetric_overdrive_shaper_assert.svh
`timescale 1ns / 1ps
`include "asymmetric_overdrive_shaper_assert.svh"

// Soft clipper for a signed Q16.16 sample stream. One request enters per cycle while
// sample_stall is low; each request passes the front register, then the curve index
// divider, which resolves one quotient bit per stage, then the table read, the rail
// multiply, the shaping adder, the gain multiply and the output register. Back
// pressure on the result side stalls only the stages that are full, so bubbles
// close up. Registers are written through the cfg port, which is always ready;
// writes are meant for idle periods.
module asymmetric_overdrive_shaper #(
	parameter int CURVE_TABLE_DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  logic signed [31:0]               sample_in,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [15:0]               displacement,
	output logic [30:0]                      harmonic_error,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [aos_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data
);

	localparam int IW = $clog2(CURVE_TABLE_DEPTH);
	localparam int NS = IW + 6;
	localparam int RW = 34 + IW;
	localparam int ST_ROM = IW + 1;
	localparam int ST_MUL = IW + 2;
	localparam int ST_Y   = IW + 3;
	localparam int ST_GM  = IW + 4;
	localparam int ST_OUT = IW + 5;

	logic [30:0]        rail_q;
	logic signed [15:0] gain_q;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;

	aos_pkg::item_t item_s [IW+1];
	aos_pkg::item_t item_s2;
	aos_pkg::item_t item_s3;
	logic [RW-1:0]  rem_s  [IW+1];
	logic [IW-1:0]  quo_s  [IW+1];
	logic [RW-1:0]  trial  [IW];

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_q <= 31'd65536;
			gain_q <= 16'sd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				aos_pkg::REG_RAIL_LIMIT:  rail_q <= cfg_data[30:0];
				aos_pkg::REG_OUTPUT_GAIN: gain_q <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// stage enables, a stage moves when empty or when the next one moves
	always_comb begin
		en[NS-1] = !vld_s[NS-1] || !result_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end
	assign sample_stall = !en[0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= sample_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// region decode and excess over the rail
	logic signed [32:0] xe_c;
	logic signed [32:0] le_c;
	logic signed [32:0] ex_c;
	logic               up_c;
	logic               lo_c;
	logic [30:0]        excess_c;
	always_comb begin
		xe_c = {sample_in[31], sample_in};
		le_c = {2'b00, rail_q};
		up_c = xe_c > le_c;
		lo_c = xe_c < -le_c;
		ex_c = up_c ? (xe_c - le_c) : (-xe_c - le_c);
		excess_c = ex_c[30:0];
	end

	// index divider, one quotient bit per stage, msb first
	always_comb begin
		for (int i = 0; i < IW; i++) begin
			trial[i] = RW'({rail_q, 3'b000}) << (IW - 1 - i);
		end
	end

	// front register, then the divider stages
	always_ff @(posedge clk) begin
		if (en[0]) begin
			item_s[0].up   <= up_c;
			item_s[0].lo   <= lo_c;
			item_s[0].zero <= rail_q == 31'd0;
			item_s[0].sat  <= {3'b000, excess_c} >= {rail_q, 3'b000};
			item_s[0].x    <= sample_in;
			rem_s[0]       <= RW'(excess_c) * RW'(CURVE_TABLE_DEPTH);
			quo_s[0]       <= '0;
		end
		for (int i = 0; i < IW; i++) begin
			if (en[i+1]) begin
				item_s[i+1] <= item_s[i];
				if (rem_s[i] >= trial[i]) begin
					rem_s[i+1] <= rem_s[i] - trial[i];
					quo_s[i+1] <= quo_s[i] | (IW'(1) << (IW - 1 - i));
				end else begin
					rem_s[i+1] <= rem_s[i];
					quo_s[i+1] <= quo_s[i];
				end
			end
		end
	end

	// curve table read
	logic [16:0] tanh_s2;
	logic [16:0] exp_s2;
	aos_curve_rom #(
		.DEPTH (CURVE_TABLE_DEPTH),
		.AW    (IW)
	) u_curve_rom (
		.clk    (clk),
		.en     (en[ST_ROM]),
		.addr   (item_s[IW].sat ? IW'(0) : quo_s[IW]),
		.tanh_q (tanh_s2),
		.exp_q  (exp_s2)
	);

	always_ff @(posedge clk) begin
		if (en[ST_ROM]) item_s2 <= item_s[IW];
	end

	// rail times curve factor
	logic [16:0] fac_c;
	logic [47:0] prod_s3;
	always_comb begin
		if (item_s2.sat) fac_c = aos_pkg::ONE_Q16;
		else if (item_s2.up) fac_c = tanh_s2;
		else fac_c = aos_pkg::ONE_Q16 - exp_s2;
	end

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			item_s3 <= item_s2;
			prod_s3 <= 48'(rail_q) * 48'(fac_c);
		end
	end

	// shaped value, error and wrapped magnitude
	logic [31:0]        sh_c;
	logic signed [33:0] y_c;
	logic signed [34:0] diff_c;
	logic [34:0]        adiff_c;
	logic [33:0]        mag_c;
	logic [30:0]        err_s4;
	logic [23:0]        w_s4;
	logic               zero_s4;
	always_comb begin
		sh_c = prod_s3[47:16];
		if (item_s3.up) y_c = $signed({3'b000, rail_q}) + $signed({2'b00, sh_c});
		else if (item_s3.lo) y_c = -$signed({2'b00, sh_c});
		else y_c = {{2{item_s3.x[31]}}, item_s3.x};
		diff_c = {{3{item_s3.x[31]}}, item_s3.x} - {y_c[33], y_c};
		adiff_c = diff_c[34] ? $unsigned(-diff_c) : $unsigned(diff_c);
		mag_c = y_c[33] ? $unsigned(-y_c) : $unsigned(y_c);
	end

	always_ff @(posedge clk) begin
		if (en[ST_Y]) begin
			err_s4  <= (adiff_c > aos_pkg::ERR_MAX) ? 31'h7FFF_FFFF : adiff_c[30:0];
			w_s4    <= mag_c[23:0];
			zero_s4 <= item_s3.zero;
		end
	end

	// gain magnitude times wrapped magnitude
	logic [15:0] gm_c;
	logic [39:0] gp_s5;
	logic        neg_s5;
	logic [30:0] err_s5;
	logic        zero_s5;
	assign gm_c = gain_q[15] ? $unsigned(-gain_q) : $unsigned(gain_q);

	always_ff @(posedge clk) begin
		if (en[ST_GM]) begin
			gp_s5   <= 40'(gm_c) * 40'(w_s4);
			neg_s5  <= gain_q[15];
			err_s5  <= err_s4;
			zero_s5 <= zero_s4;
		end
	end

	// output register, zero rail forces zeros
	logic [15:0] pq_c;
	assign pq_c = gp_s5[39:24];

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			if (zero_s5) begin
				displacement   <= '0;
				harmonic_error <= '0;
			end else begin
				displacement   <= neg_s5 ? -$signed(pq_c) : $signed(pq_c);
				harmonic_error <= err_s5;
			end
		end
	end

	assign result_valid = vld_s[ST_OUT];

	`AOS_ASSERT_NOW(a_empty_out_no_stall, !result_valid, !sample_stall)
	`AOS_ASSERT_NOW(a_stall_only_backpressure, sample_stall, result_valid && result_stall)
	`AOS_ASSERT_NOW(a_drain_frees_input, result_valid && !result_stall, !sample_stall)
	`AOS_ASSERT_NEXT(a_accept_fills_front, sample_valid && !sample_stall, vld_s[0])

endmodule

@@ sim/tb_asymmetric_overdrive_shaper.sv @@
// self-checking testbench of the asymmetric overdrive shaper
// depends on aos_pkg and the asymmetric_overdrive_shaper rtl
`timescale 1ns / 1ps

module tb_asymmetric_overdrive_shaper;

	localparam int TABLE_DEPTH = 1024;
	localparam logic [aos_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [aos_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		logic signed [15:0] disp;
		logic [30:0]        err;
	} shaped_t;

	// predicts the shaped outputs of each accepted request and checks results in order
	class shaper_scoreboard;
		longint unsigned exp_tab[TABLE_DEPTH];
		longint unsigned tanh_tab[TABLE_DEPTH];
		longint rail;
		longint gain;
		shaped_t pending_shapes[$];
		int errors;

		function new();
			longint unsigned h, term, r, r2, p, q, den, num;
			h = (64'd8 << 32) / TABLE_DEPTH;
			term = aos_pkg::ONE_Q32;
			r = aos_pkg::ONE_Q32;
			// exp(-8/depth) by taylor series in q32
			for (int n = 1; n <= 12; n++) begin
				term = ((term * h) >> 32) / n;
				if (n % 2) r = r - term;
				else r = r + term;
			end
			if (r >= aos_pkg::ONE_Q32) r = aos_pkg::ONE_Q32 - 1;
			r2 = (r * r + 64'h8000_0000) >> 32;
			p = aos_pkg::ONE_Q32;
			q = aos_pkg::ONE_Q32;
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				den = aos_pkg::ONE_Q32 + q;
				num = (aos_pkg::ONE_Q32 - q) << 16;
				exp_tab[k] = (p + 32768) >> 16;
				tanh_tab[k] = (num + den / 2) / den;
				p = (p * r + 64'h8000_0000) >> 32;
				q = (q * r2 + 64'h8000_0000) >> 32;
			end
			rail = 65536;
			gain = 256;
			errors = 0;
		endfunction

		function void write_reg(logic [aos_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == aos_pkg::REG_RAIL_LIMIT) rail = longint'(data[30:0]);
			else if (idx == aos_pkg::REG_OUTPUT_GAIN) gain = longint'($signed(data[15:0]));
		endfunction

		function void note_sample(logic signed [31:0] sample);
			longint x, y, err, idx, t, e, mag, w, gm, prod, disp;
			shaped_t s;
			x = sample;
			if (rail == 0) begin
				s.disp = '0;
				s.err = '0;
				pending_shapes.push_back(s);
				return;
			end
			// three regions around the rail
			if (x > rail) begin
				idx = ((x - rail) * TABLE_DEPTH) / (rail * 8);
				t = (idx >= TABLE_DEPTH) ? 65536 : longint'(tanh_tab[idx]);
				y = rail + ((rail * t) >>> 16);
			end else if (x < -rail) begin
				idx = ((-x - rail) * TABLE_DEPTH) / (rail * 8);
				e = (idx >= TABLE_DEPTH) ? 0 : longint'(exp_tab[idx]);
				y = -((rail * (65536 - e)) >>> 16);
			end else begin
				y = x;
			end
			err = x - y;
			if (err < 0) err = -err;
			if (err > 64'sd2147483647) err = 64'sd2147483647;
			mag = (y < 0) ? -y : y;
			w = mag & 64'hFF_FFFF;
			gm = (gain < 0) ? -gain : gain;
			prod = (gm * w) >>> 24;
			disp = (gain < 0) ? -prod : prod;
			s.disp = disp[15:0];
			s.err = err[30:0];
			pending_shapes.push_back(s);
		endfunction

		function void check_result(logic signed [15:0] disp, logic [30:0] err);
			shaped_t s;
			if (pending_shapes.size() == 0) begin
				$error("result with no request outstanding: disp %0d err %0d", disp, err);
				errors++;
				return;
			end
			s = pending_shapes.pop_front();
			if (disp !== s.disp) begin
				$error("displacement: expected %0d actual %0d", s.disp, disp);
				errors++;
			end
			if (err !== s.err) begin
				$error("harmonic_error: expected %0d actual %0d", s.err, err);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [31:0] sample_in = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [15:0] displacement;
	logic [30:0] harmonic_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [aos_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	shaper_scoreboard board = new();
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	asymmetric_overdrive_shaper dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample_in(sample_in),
		.result_valid(result_valid), .result_stall(result_stall),
		.displacement(displacement), .harmonic_error(harmonic_error),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// watchdog
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: check, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_result(displacement, harmonic_error);
		if (hold_req) begin
			hold_left = 400;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !quiet && ($urandom_range(99) < 19);
		end
	end

	// offer one request, with random gaps, until accepted
	task automatic send_sample(input logic signed [31:0] v);
		while (!quiet && $urandom_range(99) < 19) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_in <= v;
		do @(posedge clk); while (sample_stall);
		board.note_sample(v);
	endtask

	// drain the pipeline before touching registers
	task automatic settle();
		sample_valid <= 1'b0;
		while (board.pending_shapes.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(input logic [aos_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// random sample: mostly near the rail, some anywhere
	function automatic logic signed [31:0] pick_sample(longint rail);
		longint span, v;
		longint unsigned r;
		r = {$urandom, $urandom};
		span = rail * 10;
		if (span > 64'sd4294967296) span = 64'sd4294967296;
		case ($urandom_range(3))
			0: v = longint'($signed($urandom));
			1: v = rail + longint'(r % (span + 1));
			2: v = -rail - longint'(r % (span + 1));
			default: v = longint'(r % (2 * rail + 1)) - rail;
		endcase
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++) send_sample(pick_sample(board.rail));
	endtask

	initial begin
		logic [31:0] rnd;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset rail of 1.0: region edges, past the table end, field extremes
		send_sample(32'sd0);
		send_sample(32'sd65536);
		send_sample(-32'sd65536);
		send_sample(32'sd65537);
		send_sample(-32'sd65537);
		send_sample(32'sd65536 + 32'sd589823);
		send_sample(32'sd65536 + 32'sd589824);
		send_sample(-32'sd65536 - 32'sd589823);
		send_sample(-32'sd65536 - 32'sd589824);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'sd16777216 + 32'sd300);
		settle();

		// zero rail forces zeros, spare indexes are ignored
		write_reg(aos_pkg::REG_RAIL_LIMIT, 32'h8000_0000);
		write_reg(aos_pkg::REG_OUTPUT_GAIN, 32'hFFFF_8000);
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		random_run(20);
		settle();

		// widest rail: saturating error at the most negative sample
		write_reg(aos_pkg::REG_RAIL_LIMIT, 32'hFFFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		random_run(20);
		settle();

		write_reg(aos_pkg::REG_RAIL_LIMIT, 32'd1);
		write_reg(aos_pkg::REG_OUTPUT_GAIN, 32'h0000_7FFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		random_run(30);
		settle();

		// long receiver hold while requests keep coming
		write_reg(aos_pkg::REG_RAIL_LIMIT, 32'd65536 * 3);
		write_reg(aos_pkg::REG_OUTPUT_GAIN, 32'd0);
		hold_req = 1'b1;
		random_run(60);
		settle();

		// several random settings, one without any idling
		for (int ph = 0; ph < 8; ph++) begin
			rnd = $urandom;
			write_reg(aos_pkg::REG_RAIL_LIMIT,
				(ph % 2) ? ($urandom_range(1, 1 << 20) | (rnd & 32'h8000_0000))
				: $urandom);
			write_reg(aos_pkg::REG_OUTPUT_GAIN, $urandom);
			quiet = (ph == 3);
			random_run(50);
			settle();
		end
		quiet = 1'b0;

		if (board.errors == 0 && board.pending_shapes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
